// File: sv/spring_tension_classifier_macros.svh
// Assertion macros used by the spring tension classifier controller
`ifndef SPRING_TENSION_CLASSIFIER_MACROS_SVH
`define SPRING_TENSION_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define STC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stc check failed");

// next-cycle implication
`define STC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stc check failed");

`endif

// File: sv/stc_pkg.sv
// Shared constants, codes and controller/datapath interface types
package stc_pkg;

   localparam int HALF_WINDOW = 6;
   localparam int SLOT_COUNT  = 2 * HALF_WINDOW;
   localparam int IDX_W       = $clog2(SLOT_COUNT);
   localparam int DATA_W      = 8;
   localparam int SUM_W       = $clog2(HALF_WINDOW * 255 + 1);
   // reciprocal of HALF_WINDOW, exact for every sum of HALF_WINDOW samples
   localparam int DIV_SHIFT   = $clog2(HALF_WINDOW * HALF_WINDOW * 255 + 1);
   localparam int DIV_MUL     = (2 ** DIV_SHIFT + HALF_WINDOW - 1) / HALF_WINDOW;
   localparam int PROD_W      = SUM_W + $clog2(DIV_MUL + 1);
   localparam int GRADE_W     = 3;
   localparam int FUNC_W      = 2;

   localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EVAL   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEAK   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [GRADE_W-1:0] GRADE_NONE   = 3'd0;
   localparam logic [GRADE_W-1:0] GRADE_ERROR  = 3'd1;
   localparam logic [GRADE_W-1:0] GRADE_HIGH   = 3'd2;
   localparam logic [GRADE_W-1:0] GRADE_MEDIUM = 3'd3;
   localparam logic [GRADE_W-1:0] GRADE_LOW    = 3'd4;

   localparam logic [DATA_W-1:0] HEAD_LOW_EXCL  = 8'd20;
   localparam logic [DATA_W-1:0] HEAD_HIGH_EXCL = 8'd80;
   localparam logic [DATA_W-1:0] TAIL_AVG_LIMIT = 8'd220;
   localparam logic [DATA_W-1:0] LIMIT_ERR      = 8'd190;
   localparam logic [DATA_W-1:0] LIMIT_HIGH     = 8'd150;
   localparam logic [DATA_W-1:0] LIMIT_MED      = 8'd110;
   localparam logic [DATA_W-1:0] LIMIT_LOW      = 8'd90;
   localparam logic [DATA_W-1:0] DATA_MAX       = 8'd255;

   typedef struct packed {
      logic             capture;
      logic             do_record;
      logic             do_clear;
      logic             acc_start;
      logic             acc_step;
      logic             head_save;
      logic             tail_save;
      logic             peak_save;
      logic             rsp_load;
      logic [IDX_W-1:0] idx;
   } stc_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
   } stc_stat_type;

endpackage

// File: sv/stc_dpath.sv
// Datapath: sample slots, accumulator, constant divider, grading and result registers
module stc_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  stc_pkg::stc_cmd_type         cmd,
   output stc_pkg::stc_stat_type        stat,
   input  logic [stc_pkg::FUNC_W-1:0]   req_func,
   input  logic [stc_pkg::DATA_W-1:0]   req_rev_count,
   input  logic [stc_pkg::DATA_W-1:0]   req_period,
   output logic [stc_pkg::GRADE_W-1:0]  rsp_status,
   output logic [stc_pkg::DATA_W-1:0]   rsp_peak_period,
   output logic [stc_pkg::DATA_W-1:0]   rsp_first_average,
   output logic [stc_pkg::DATA_W-1:0]   rsp_first_minimum,
   output logic [stc_pkg::DATA_W-1:0]   rsp_last_average
);
   import stc_pkg::*;

   function automatic logic [GRADE_W-1:0] grade_of(
      input logic [DATA_W-1:0] head_avg,
      input logic [DATA_W-1:0] tail_avg,
      input logic [DATA_W-1:0] hi
   );
      logic [GRADE_W-1:0] g;
      g = GRADE_ERROR;
      if ((head_avg > HEAD_LOW_EXCL && head_avg < HEAD_HIGH_EXCL) ||
          tail_avg > TAIL_AVG_LIMIT) begin
         if (hi > LIMIT_ERR)       g = GRADE_ERROR;
         else if (hi > LIMIT_HIGH) g = GRADE_HIGH;
         else if (hi > LIMIT_MED)  g = GRADE_MEDIUM;
         else if (hi > LIMIT_LOW)  g = GRADE_LOW;
         else                      g = GRADE_ERROR;
      end
      return g;
   endfunction

   // captured request
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [DATA_W-1:0] rev_ff, rev_in;
   logic [DATA_W-1:0] per_ff, per_in;

   // held state
   logic [DATA_W-1:0]  store_ff [SLOT_COUNT];
   logic [DATA_W-1:0]  store_in [SLOT_COUNT];
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [DATA_W-1:0]  last_rev_ff, last_rev_in;
   logic [GRADE_W-1:0] grade_ff, grade_in;
   logic [DATA_W-1:0]  peak_ff, peak_in;
   logic [DATA_W-1:0]  head_avg_ff, head_avg_in;
   logic [DATA_W-1:0]  head_min_ff, head_min_in;
   logic [DATA_W-1:0]  tail_avg_ff, tail_avg_in;

   // accumulator
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DATA_W-1:0] min_ff, min_in;
   logic [DATA_W-1:0] max_ff, max_in;

   // result registers
   logic [GRADE_W-1:0] out_status_ff, out_status_in;
   logic [DATA_W-1:0]  out_peak_ff, out_peak_in;
   logic [DATA_W-1:0]  out_favg_ff, out_favg_in;
   logic [DATA_W-1:0]  out_fmin_ff, out_fmin_in;
   logic [DATA_W-1:0]  out_lavg_ff, out_lavg_in;

   logic [DATA_W-1:0] rd_data;
   logic [PROD_W-1:0] prod;
   logic [DATA_W-1:0] quo;
   logic [IDX_W-1:0]  wr_slot;
   logic [IDX_W:0]    slot_next;

   assign rd_data   = store_ff[cmd.idx];
   // floor(sum / HALF_WINDOW) by reciprocal multiply on the finished sum
   assign prod      = PROD_W'(sum_ff) * PROD_W'(DIV_MUL);
   assign quo       = prod[DIV_SHIFT +: DATA_W];
   // stray pointer falls back to the first ring slot
   assign wr_slot   = ({1'b0, slot_ff} >= (IDX_W+1)'(SLOT_COUNT)) ?
                      IDX_W'(HALF_WINDOW) : slot_ff;
   assign slot_next = {1'b0, wr_slot} + (IDX_W+1)'(1);

   always_comb begin
      func_in = func_ff;
      rev_in  = rev_ff;
      per_in  = per_ff;
      if (cmd.capture) begin
         func_in = req_func;
         rev_in  = req_rev_count;
         per_in  = req_period;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.acc_start) begin
         sum_in = '0;
         min_in = DATA_MAX;
         max_in = '0;
      end else if (cmd.acc_step) begin
         sum_in = sum_ff + SUM_W'(rd_data);
         min_in = (rd_data < min_ff) ? rd_data : min_ff;
         max_in = (rd_data > max_ff) ? rd_data : max_ff;
      end
   end

   always_comb begin
      store_in    = store_ff;
      slot_in     = slot_ff;
      last_rev_in = last_rev_ff;
      grade_in    = grade_ff;
      peak_in     = peak_ff;
      head_avg_in = head_avg_ff;
      head_min_in = head_min_ff;
      tail_avg_in = tail_avg_ff;
      if (cmd.do_clear) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            store_in[i] = '0;
         end
         slot_in     = '0;
         last_rev_in = '0;
         grade_in    = GRADE_NONE;
         peak_in     = '0;
         head_avg_in = '0;
         head_min_in = '0;
         tail_avg_in = '0;
      end
      if (cmd.do_record && rev_ff != last_rev_ff) begin
         last_rev_in       = rev_ff;
         store_in[wr_slot] = per_ff;
         slot_in           = (slot_next >= (IDX_W+1)'(SLOT_COUNT)) ?
                             IDX_W'(HALF_WINDOW) : slot_next[IDX_W-1:0];
      end
      if (cmd.head_save) begin
         head_avg_in = quo;
         head_min_in = min_ff;
      end
      if (cmd.tail_save) begin
         tail_avg_in = quo;
         peak_in     = max_ff;
         grade_in    = grade_of(head_avg_ff, quo, max_ff);
      end
      if (cmd.peak_save) begin
         peak_in = max_in;
      end
   end

   always_comb begin
      out_status_in = out_status_ff;
      out_peak_in   = out_peak_ff;
      out_favg_in   = out_favg_ff;
      out_fmin_in   = out_fmin_ff;
      out_lavg_in   = out_lavg_ff;
      if (cmd.rsp_load) begin
         out_status_in = grade_ff;
         out_peak_in   = peak_ff;
         out_favg_in   = head_avg_ff;
         out_fmin_in   = head_min_ff;
         out_lavg_in   = tail_avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            store_ff[i] <= '0;
         end
         slot_ff     <= '0;
         last_rev_ff <= '0;
         grade_ff    <= GRADE_NONE;
         peak_ff     <= '0;
         head_avg_ff <= '0;
         head_min_ff <= '0;
         tail_avg_ff <= '0;
      end else begin
         store_ff    <= store_in;
         slot_ff     <= slot_in;
         last_rev_ff <= last_rev_in;
         grade_ff    <= grade_in;
         peak_ff     <= peak_in;
         head_avg_ff <= head_avg_in;
         head_min_ff <= head_min_in;
         tail_avg_ff <= tail_avg_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      rev_ff        <= rev_in;
      per_ff        <= per_in;
      sum_ff        <= sum_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      out_status_ff <= out_status_in;
      out_peak_ff   <= out_peak_in;
      out_favg_ff   <= out_favg_in;
      out_fmin_ff   <= out_fmin_in;
      out_lavg_ff   <= out_lavg_in;
   end

   assign stat.func         = func_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_peak_period   = out_peak_ff;
   assign rsp_first_average = out_favg_ff;
   assign rsp_first_minimum = out_fmin_ff;
   assign rsp_last_average  = out_lavg_ff;

endmodule

// File: sv/stc_ctrl.sv
// Controller: request sequencing, slot walks, average steps and response handshake
`include "spring_tension_classifier_macros.svh"

module stc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stc_pkg::stc_cmd_type  cmd,
   input  stc_pkg::stc_stat_type stat
);
   import stc_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DECODE    = 4'd1;
   localparam logic [3:0] ST_HEAD_WALK = 4'd2;
   localparam logic [3:0] ST_HEAD_DIV  = 4'd3;
   localparam logic [3:0] ST_TAIL_WALK = 4'd4;
   localparam logic [3:0] ST_TAIL_DIV  = 4'd5;
   localparam logic [3:0] ST_PEAK_WALK = 4'd6;
   localparam logic [3:0] ST_DONE      = 4'd7;

   localparam logic [IDX_W-1:0]  HEAD_LAST = IDX_W'(HALF_WINDOW - 1);
   localparam logic [IDX_W-1:0]  TAIL_LAST = IDX_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W-1:0]  TAIL_FIRST = IDX_W'(HALF_WINDOW);

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.idx      = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in  = '0;
            case (stat.func)
               FUNC_RECORD: begin
                  cmd.do_record = 1'b1;
                  state_in      = ST_DONE;
               end
               FUNC_EVAL: begin
                  cmd.acc_start = 1'b1;
                  state_in      = ST_HEAD_WALK;
               end
               FUNC_PEAK: begin
                  cmd.acc_start = 1'b1;
                  state_in      = ST_PEAK_WALK;
               end
               FUNC_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  state_in     = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_HEAD_WALK: begin
            cmd.acc_step = 1'b1;
            cnt_in       = cnt_ff + IDX_W'(1);
            if (cnt_ff == HEAD_LAST) begin
               state_in = ST_HEAD_DIV;
            end
         end
         ST_HEAD_DIV: begin
            // sum restarts before the ring pass
            cmd.head_save = 1'b1;
            cmd.acc_start = 1'b1;
            cnt_in        = TAIL_FIRST;
            state_in      = ST_TAIL_WALK;
         end
         ST_TAIL_WALK: begin
            cmd.acc_step = 1'b1;
            cnt_in       = cnt_ff + IDX_W'(1);
            if (cnt_ff == TAIL_LAST) begin
               state_in = ST_TAIL_DIV;
            end
         end
         ST_TAIL_DIV: begin
            cmd.tail_save = 1'b1;
            state_in      = ST_DONE;
         end
         ST_PEAK_WALK: begin
            cmd.acc_step = 1'b1;
            cnt_in       = cnt_ff + IDX_W'(1);
            if (cnt_ff == TAIL_LAST) begin
               cmd.peak_save = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait until the response register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `STC_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && !req_stall, state_ff == ST_DECODE)
   `STC_ASSERT_NOW(a_walk_range, clock, reset, cmd.acc_step, {1'b0, cnt_ff} < (IDX_W+1)'(SLOT_COUNT))
   `STC_ASSERT_NOW(a_rsp_from_done, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `STC_ASSERT_NEXT(a_tail_start, clock, reset, state_ff == ST_HEAD_DIV, state_ff == ST_TAIL_WALK && cnt_ff == TAIL_FIRST)

endmodule

// File: sv/spring_tension_classifier.sv
// Top level of the spring tension classifier: controller plus datapath
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_func, req_rev_count, req_period
//   rsp      out        rsp_valid / rsp_stall  rsp_status, rsp_peak_period,
//                                              rsp_first_average, rsp_first_minimum,
//                                              rsp_last_average
//
// Record and clear go from decode straight to the response; peak walks all slots first.
// Evaluate makes two slot walks, one slot per cycle, each followed by a
// reciprocal-multiply divide by HALF_WINDOW.
// One request in flight; req_stall is high from accept until its response is loaded.
// A stalled response holds while the next request is already accepted and processed.
// Synchronous reset zeroes all slots and held values.
module spring_tension_classifier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [stc_pkg::FUNC_W-1:0]   req_func,
   input  logic [stc_pkg::DATA_W-1:0]   req_rev_count,
   input  logic [stc_pkg::DATA_W-1:0]   req_period,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [stc_pkg::GRADE_W-1:0]  rsp_status,
   output logic [stc_pkg::DATA_W-1:0]   rsp_peak_period,
   output logic [stc_pkg::DATA_W-1:0]   rsp_first_average,
   output logic [stc_pkg::DATA_W-1:0]   rsp_first_minimum,
   output logic [stc_pkg::DATA_W-1:0]   rsp_last_average
);
   import stc_pkg::*;

   stc_cmd_type  cmd;
   stc_stat_type stat;

   stc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   stc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_rev_count     (req_rev_count),
      .req_period        (req_period),
      .rsp_status        (rsp_status),
      .rsp_peak_period   (rsp_peak_period),
      .rsp_first_average (rsp_first_average),
      .rsp_first_minimum (rsp_first_minimum),
      .rsp_last_average  (rsp_last_average)
   );

endmodule
